### sv/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

### sv/imd_pkg.sv
package imd_pkg;

  localparam int unsigned NumAxes = 3;

  // gravity limit of 0.8 in q2.14, strict compares are exact at this integer
  localparam logic signed [15:0] GRAV_LIMIT     = 16'sd13107;
  localparam logic signed [15:0] GRAV_LIMIT_NEG = -16'sd13107;

  localparam logic [2:0] FACE_BOTTOM = 3'd0;
  localparam logic [2:0] FACE_TOP    = 3'd1;
  localparam logic [2:0] FACE_BACK   = 3'd2;
  localparam logic [2:0] FACE_FRONT  = 3'd3;
  localparam logic [2:0] FACE_LEFT   = 3'd4;
  localparam logic [2:0] FACE_RIGHT  = 3'd5;
  localparam logic [2:0] FACE_NONE   = 3'd6;

  localparam logic [1:0] REG_ACCEL_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GYRO_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_HOLD_TIME_MS    = 2'd2;

  localparam logic [15:0] ACCEL_THRESHOLD_RST = 16'd3277;
  localparam logic [15:0] GYRO_THRESHOLD_RST  = 16'd1000;
  localparam logic [31:0] HOLD_TIME_MS_RST    = 32'd1000;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] grav_x;
    logic signed [15:0] grav_y;
    logic signed [15:0] grav_z;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic       moving;
    logic [2:0] face;
    logic       face_changed;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_word_t;

  // per gravity axis: component below -0.8 / above 0.8
  typedef struct packed {
    logic below;
    logic above;
  } grav_flags_t;

endpackage

### sv/imd_ifs.sv
interface imd_sample_if;
  logic              valid;
  logic              ready;
  imd_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imd_result_if;
  logic              valid;
  logic              ready;
  imd_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/imd_mag_lane.sv
module imd_mag_lane (
  input  logic signed [15:0] value,
  input  logic [15:0]        threshold,
  output logic               hit
);

  logic [16:0] mag;

  // exact magnitude, -32768 gives 32768
  always_comb begin
    if (value[15]) begin
      mag = 17'({1'b0, ~value}) + 17'd1;
    end else begin
      mag = {1'b0, value};
    end
  end

  assign hit = mag > {1'b0, threshold};

endmodule

### sv/imd_grav_lane.sv
module imd_grav_lane (
  input  logic signed [15:0]    value,
  output imd_pkg::grav_flags_t  flags
);

  assign flags.below = value < imd_pkg::GRAV_LIMIT_NEG;
  assign flags.above = value > imd_pkg::GRAV_LIMIT;

endmodule

### sv/imd_merge.sv
`include "assert_macros.svh"

module imd_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [5:0]           motion_hits,
  input  imd_pkg::grav_flags_t grav_flags [imd_pkg::NumAxes],
  input  logic [31:0]          now_ms,
  input  logic [31:0]          hold_time_ms,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output imd_pkg::result_t     out_data
);

  logic              motion_now;
  logic [31:0]       elapsed;
  logic [2:0]        face_next;
  imd_pkg::result_t  res_next;
  logic [31:0]       last_motion_time;
  logic [2:0]        previous_face;
  logic              skid_valid;
  imd_pkg::result_t  skid_data;
  logic              out_fire;

  assign motion_now = |motion_hits;
  assign elapsed    = now_ms - last_motion_time;

  // priority: z, then x, then y; below before above
  always_comb begin
    if (grav_flags[2].below) begin
      face_next = imd_pkg::FACE_BOTTOM;
    end else if (grav_flags[2].above) begin
      face_next = imd_pkg::FACE_TOP;
    end else if (grav_flags[0].below) begin
      face_next = imd_pkg::FACE_BACK;
    end else if (grav_flags[0].above) begin
      face_next = imd_pkg::FACE_FRONT;
    end else if (grav_flags[1].below) begin
      face_next = imd_pkg::FACE_LEFT;
    end else if (grav_flags[1].above) begin
      face_next = imd_pkg::FACE_RIGHT;
    end else begin
      face_next = imd_pkg::FACE_NONE;
    end
  end

  always_comb begin
    res_next.moving       = motion_now || (elapsed < hold_time_ms);
    res_next.face         = face_next;
    res_next.face_changed = face_next != previous_face;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_motion_time <= '0;
      previous_face    <= imd_pkg::FACE_BOTTOM;
    end else if (accept) begin
      previous_face <= face_next;
      if (motion_now) begin
        last_motion_time <= now_ms;
      end
    end
  end

  // output register plus skid word, input stalls only when both are full
  assign in_ready = !skid_valid;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !out_ready) begin
        skid_data <= res_next;
      end else begin
        out_data <= res_next;
      end
    end
  end

  `ASSERT_CLK(a_skid_behind_out, clk, rst, skid_valid |-> out_valid, "skid word without output word")
  `ASSERT_CLK(a_motion_stamp, clk, rst, (accept && motion_now) |=> (last_motion_time == $past(now_ms)), "motion timestamp not stored")
  `ASSERT_CLK(a_face_tracked, clk, rst, accept |=> (previous_face == $past(face_next)), "previous face not updated")
  `ASSERT_NEVER(a_no_accept_when_full, clk, rst, accept && skid_valid, "word accepted with both buffers full")

endmodule

### sv/imu_motion_and_face_detector_unit.sv
// One IMU sample word in, one result word out. A sample is taken every cycle unless both output
// words are held; its result is registered in the output word, or in the skid word while the
// output is stalled. Six magnitude lanes and three gravity lanes evaluate the axes side by side
// and a single merge stage applies the hold timer and face priority. Results pass through a
// two-word output buffer, so the input stops only while both words are held. Configuration
// writes are always ready and are registered before the lanes and the merge stage use them.
module imu_motion_and_face_detector_unit (
  input  logic          clk,
  input  logic          rst,
  imd_sample_if.sink    sample,
  imd_result_if.source  result,
  imd_cfg_if.sink       cfg
);

  logic [15:0]          accel_threshold;
  logic [15:0]          gyro_threshold;
  logic [31:0]          hold_time_ms;
  logic signed [15:0]   gyro_axis  [imd_pkg::NumAxes];
  logic signed [15:0]   accel_axis [imd_pkg::NumAxes];
  logic signed [15:0]   grav_axis  [imd_pkg::NumAxes];
  logic [5:0]           motion_hits;
  imd_pkg::grav_flags_t grav_flags [imd_pkg::NumAxes];
  logic                 accept;
  logic                 in_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_threshold <= imd_pkg::ACCEL_THRESHOLD_RST;
      gyro_threshold  <= imd_pkg::GYRO_THRESHOLD_RST;
      hold_time_ms    <= imd_pkg::HOLD_TIME_MS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        imd_pkg::REG_ACCEL_THRESHOLD: accel_threshold <= cfg.data[15:0];
        imd_pkg::REG_GYRO_THRESHOLD:  gyro_threshold  <= cfg.data[15:0];
        imd_pkg::REG_HOLD_TIME_MS:    hold_time_ms    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign gyro_axis[0]  = sample.data.gyro_x;
  assign gyro_axis[1]  = sample.data.gyro_y;
  assign gyro_axis[2]  = sample.data.gyro_z;
  assign accel_axis[0] = sample.data.accel_x;
  assign accel_axis[1] = sample.data.accel_y;
  assign accel_axis[2] = sample.data.accel_z;
  assign grav_axis[0]  = sample.data.grav_x;
  assign grav_axis[1]  = sample.data.grav_y;
  assign grav_axis[2]  = sample.data.grav_z;

  for (genvar i = 0; i < imd_pkg::NumAxes; i++) begin : g_lane
    imd_mag_lane u_gyro (
      .value     (gyro_axis[i]),
      .threshold (gyro_threshold),
      .hit       (motion_hits[i])
    );
    imd_mag_lane u_accel (
      .value     (accel_axis[i]),
      .threshold (accel_threshold),
      .hit       (motion_hits[imd_pkg::NumAxes + i])
    );
    imd_grav_lane u_grav (
      .value (grav_axis[i]),
      .flags (grav_flags[i])
    );
  end

  assign sample.ready = in_ready;
  assign accept       = sample.valid && in_ready;

  imd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .motion_hits  (motion_hits),
    .grav_flags   (grav_flags),
    .now_ms       (sample.data.now_ms),
    .hold_time_ms (hold_time_ms),
    .in_ready     (in_ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_data     (result.data)
  );

endmodule

### tb/imd_scoreboard.sv
`timescale 1ns / 1ps
module imd_scoreboard
  import imd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  imd_sample_if  sample,
  imd_result_if  result,
  imd_cfg_if     cfg,
  output int     errors,
  output int     pending
);

  logic [15:0] accel_limit;
  logic [15:0] gyro_limit;
  logic [31:0] hold_ms;
  logic [31:0] motion_stamp;
  logic [2:0]  prior_face;
  result_t     predicted_reports[$];
  int          mismatch_count;

  function automatic int magnitude(logic signed [15:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic [2:0] face_from_gravity(sample_t s);
    if (s.grav_z < GRAV_LIMIT_NEG) return FACE_BOTTOM;
    if (s.grav_z > GRAV_LIMIT)     return FACE_TOP;
    if (s.grav_x < GRAV_LIMIT_NEG) return FACE_BACK;
    if (s.grav_x > GRAV_LIMIT)     return FACE_FRONT;
    if (s.grav_y < GRAV_LIMIT_NEG) return FACE_LEFT;
    if (s.grav_y > GRAV_LIMIT)     return FACE_RIGHT;
    return FACE_NONE;
  endfunction

  // updates the motion stamp and the previous face as the block does
  function automatic result_t classify_sample(sample_t s);
    result_t     r;
    logic        hit;
    logic [31:0] elapsed;
    logic [2:0]  f;
    hit = magnitude(s.gyro_x) > int'(gyro_limit) || magnitude(s.gyro_y) > int'(gyro_limit) ||
          magnitude(s.gyro_z) > int'(gyro_limit) ||
          magnitude(s.accel_x) > int'(accel_limit) || magnitude(s.accel_y) > int'(accel_limit) ||
          magnitude(s.accel_z) > int'(accel_limit);
    elapsed = s.now_ms - motion_stamp;
    if (hit) begin
      motion_stamp = s.now_ms;
    end else if (elapsed < hold_ms) begin
      hit = 1'b1;
    end
    f = face_from_gravity(s);
    r.moving       = hit;
    r.face         = f;
    r.face_changed = (f != prior_face);
    prior_face     = f;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      accel_limit  = ACCEL_THRESHOLD_RST;
      gyro_limit   = GYRO_THRESHOLD_RST;
      hold_ms      = HOLD_TIME_MS_RST;
      motion_stamp = '0;
      prior_face   = FACE_BOTTOM;
      predicted_reports.delete();
      mismatch_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ACCEL_THRESHOLD: accel_limit = cfg.data[15:0];
          REG_GYRO_THRESHOLD:  gyro_limit  = cfg.data[15:0];
          REG_HOLD_TIME_MS:    hold_ms     = cfg.data;
          default: ;
        endcase
      end
      // a word leaving now belongs to an earlier sample, so compare before predicting
      if (result.valid && result.ready) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: result word with nothing expected: moving %0b face %0d changed %0b",
                   $time, result.data.moving, result.data.face, result.data.face_changed);
          mismatch_count++;
        end else begin
          want = predicted_reports.pop_front();
          if (result.data.moving !== want.moving) begin
            $display("%0t: moving expected %0b got %0b", $time, want.moving, result.data.moving);
            mismatch_count++;
          end
          if (result.data.face !== want.face) begin
            $display("%0t: face expected %0d got %0d", $time, want.face, result.data.face);
            mismatch_count++;
          end
          if (result.data.face_changed !== want.face_changed) begin
            $display("%0t: face_changed expected %0b got %0b", $time, want.face_changed,
                     result.data.face_changed);
            mismatch_count++;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        predicted_reports.push_back(classify_sample(sample.data));
      end
    end
    errors  <= mismatch_count;
    pending <= predicted_reports.size();
  end

endmodule

### tb/imu_motion_and_face_detector_unit_test.sv
`timescale 1ns / 1ps
module imu_motion_and_face_detector_unit_test;
  import imd_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int RandomSamples = 450;
  localparam int PhaseCount    = 6;
  localparam int DrainCycles   = 20;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_BURST  = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imd_sample_if sample_ch ();
  imd_result_if result_ch ();
  imd_cfg_if    cfg_ch ();

  int errors;
  int pending;
  int cycles = 0;
  int samples_sent = 0;
  int settings_used = 0;
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;

  logic [31:0] stamp = '0;
  logic [15:0] accel_thr_now = ACCEL_THRESHOLD_RST;
  logic [15:0] gyro_thr_now  = GYRO_THRESHOLD_RST;
  logic [31:0] hold_now      = HOLD_TIME_MS_RST;

  imu_motion_and_face_detector_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  imd_scoreboard u_scoreboard (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run timed out after %0d cycles with %0d words outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RANDOM: result_ch.ready <= ($urandom_range(0, 99) < 65);
      STALL_BURST: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          result_ch.ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 12);
          result_ch.ready <= 1'b1;
        end
      end
      default: result_ch.ready <= 1'b1;
    endcase
  end

  function automatic sample_t make_sample(int gx, int gy, int gz, int ax, int ay, int az,
                                          int vx, int vy, int vz, logic [31:0] t);
    sample_t s;
    s.gyro_x  = 16'(gx);
    s.gyro_y  = 16'(gy);
    s.gyro_z  = 16'(gz);
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.grav_x  = 16'(vx);
    s.grav_y  = 16'(vy);
    s.grav_z  = 16'(vz);
    s.now_ms  = t;
    return s;
  endfunction

  // raw axis value either above or within the given limit
  function automatic logic signed [15:0] raw_axis(logic [15:0] limit, bit hot);
    int lim;
    int mag;
    lim = int'(limit);
    if (hot && lim < 32768) begin
      mag = ($urandom_range(0, 1) == 1) ? lim + 1 : int'($urandom_range(lim + 1, 32768));
    end else if (hot) begin
      mag = int'($urandom_range(0, 32768));
    end else begin
      if (lim > 32768) lim = 32768;
      mag = ($urandom_range(0, 3) == 0) ? lim : int'($urandom_range(0, lim));
    end
    if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1)) return 16'(-mag);
    return 16'(mag);
  endfunction

  // gravity component clustered around the face limits and the extremes
  function automatic logic signed [15:0] grav_axis();
    int lim;
    int v;
    lim = int'(GRAV_LIMIT);
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 32768)) - 16384;
      1: v = int'($urandom_range(lim - 1, lim + 1));
      2: v = -int'($urandom_range(lim - 1, lim + 1));
      3: v = 16384;
      4: v = -16384;
      default: v = int'($urandom_range(0, 400)) - 200;
    endcase
    return 16'(v);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    int hot_axis;
    bit [5:0] hot;
    pick = $urandom_range(0, 99);
    s.grav_x = grav_axis();
    s.grav_y = grav_axis();
    s.grav_z = grav_axis();
    if (pick < 10) begin
      s.gyro_x  = 16'($urandom);
      s.gyro_y  = 16'($urandom);
      s.gyro_z  = 16'($urandom);
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
      stamp = $urandom;
    end else begin
      hot = '0;
      if (pick < 30) begin
        hot_axis = $urandom_range(0, 5);
        hot[hot_axis] = 1'b1;
      end else if (pick < 40) begin
        hot = 6'($urandom);
      end
      s.gyro_x  = raw_axis(gyro_thr_now, hot[0]);
      s.gyro_y  = raw_axis(gyro_thr_now, hot[1]);
      s.gyro_z  = raw_axis(gyro_thr_now, hot[2]);
      s.accel_x = raw_axis(accel_thr_now, hot[3]);
      s.accel_y = raw_axis(accel_thr_now, hot[4]);
      s.accel_z = raw_axis(accel_thr_now, hot[5]);
      // mostly short steps, some right at the hold edge, some jumping back or far away
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: stamp = stamp + 32'($urandom_range(0, 300));
        6: stamp = stamp + hold_now - 32'd1 + 32'($urandom_range(0, 2));
        7: stamp = stamp - 32'($urandom_range(1, 50));
        8: stamp = $urandom;
        default: ;
      endcase
    end
    s.now_ms = stamp;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if (gaps_on) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // at least one edge passes so a word accepted this cycle is counted
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_word(input logic [1:0] index, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] a, input logic [15:0] g, input logic [31:0] h);
    wait_drained();
    // upper bits of the threshold words are don't-care
    write_word(REG_ACCEL_THRESHOLD, {16'($urandom), a});
    write_word(REG_GYRO_THRESHOLD, {16'($urandom), g});
    write_word(REG_HOLD_TIME_MS, h);
    write_word(REG_UNMAPPED, $urandom);
    cfg_ch.valid <= 1'b0;
    accel_thr_now = a;
    gyro_thr_now  = g;
    hold_now      = h;
    settings_used++;
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_ACCEL_THRESHOLD;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: limits at the boundary, every face, priority, hold and wrap
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0));
    send_sample(make_sample(1000, 0, 0, 0, 0, 0, 0, 0, -13108, 32'd5000));
    send_sample(make_sample(0, -1001, 0, 0, 0, 0, 0, 0, -13107, 32'd5001));
    send_sample(make_sample(0, 0, 32767, 0, 0, 0, 0, 0, 13108, 32'd5100));
    send_sample(make_sample(0, 0, 0, -32768, 0, 0, -13108, 0, 0, 32'd5200));
    send_sample(make_sample(0, 0, 0, 0, 3278, 0, 13108, 0, 0, 32'd5300));
    send_sample(make_sample(0, 0, 0, 0, 0, -3277, 0, -13108, 0, 32'd6299));
    send_sample(make_sample(0, 0, 0, 0, 0, 3277, 0, 13108, 0, 32'd6300));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 13107, 0, 32'd6300));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 16384, 16384, -16384, 32'd6301));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, -16384, -16384, 13107, 32'd6302));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 13107, -13108, 0, 32'd6303));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 16384, 16384, 16384, 32'd6304));
    send_sample(make_sample(0, 0, -32768, 0, 0, 0, 16384, 16384, 16384, 32'hFFFF_FFF0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0010));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFE0));
    send_sample(make_sample(-1000, 1000, 0, 3277, -3277, 0, 0, 0, 0, 32'hFFFF_FFE0));

    // zero limits and no hold
    program_regs(16'd0, 16'd0, 32'd0);
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd100));
    send_sample(make_sample(0, 0, 0, 0, 0, 1, 0, 0, 0, 32'd100));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd100));
    send_sample(make_sample(-1, 0, 0, 0, 0, 0, 0, 0, -16384, 32'd100));

    // widest limits and the longest hold
    program_regs(16'd32768, 16'd32768, 32'hFFFF_FFFF);
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 32'd100));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 32'd99));
    stamp = 32'd99;

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: program_regs(ACCEL_THRESHOLD_RST, GYRO_THRESHOLD_RST, HOLD_TIME_MS_RST);
        1: program_regs(16'd0, 16'd0, 32'd0);
        2: program_regs(16'd32768, 16'd32768, 32'hFFFF_FFFF);
        3: program_regs(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                        32'($urandom_range(0, 2000)));
        4: program_regs(16'd16, 16'd16, 32'd50);
        default: begin
          stamp = 32'hFFFF_FF00;
          program_regs(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                       $urandom);
        end
      endcase
      stall_mode <= p % 3;
      gaps_on = (p != 0);
      for (int n = 0; n < RandomSamples / PhaseCount; n++) begin
        send_sample(random_sample());
        pace();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d samples under %0d register settings in %0d cycles", samples_sent,
             settings_used, cycles);
    $display("sender ran in bursts, receiver stalled freely, randomly and in long runs");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/imd_pkg.sv
sv/imd_ifs.sv
sv/imd_mag_lane.sv
sv/imd_grav_lane.sv
sv/imd_merge.sv
sv/imu_motion_and_face_detector_unit.sv
tb/imd_scoreboard.sv
tb/imu_motion_and_face_detector_unit_test.sv
